### rtl/core/ptw_pkg.sv
// ============================================================================
// ptw_pkg
// Types, codes and address helpers for the four-level page table walker.
// ============================================================================
package ptw_pkg;

    localparam int ADDR_W         = 52;
    localparam int PHYS_ADDR_BITS = 52;
    localparam int VA_W           = 48;
    localparam int DATA_W         = 64;
    localparam int PADDR_W        = 4;

    localparam logic [ADDR_W-1:0] PA_MASK =
        {ADDR_W{1'b1}} >> (ADDR_W - PHYS_ADDR_BITS);

    localparam logic [PADDR_W-1:0] REG_ROOT_TABLE_ADDR = PADDR_W'(0);

    localparam logic FUNC_TRANSLATE = 1'b0;
    localparam logic FUNC_READ_RESP = 1'b1;

    localparam logic KIND_READ_REQ = 1'b0;
    localparam logic KIND_DONE     = 1'b1;

    localparam logic [1:0] PAGE_4K = 2'd0;
    localparam logic [1:0] PAGE_2M = 2'd1;
    localparam logic [1:0] PAGE_1G = 2'd2;

    typedef enum logic [1:0] {
        LVL_PML4 = 2'd0,
        LVL_PDP  = 2'd1,
        LVL_PD   = 2'd2,
        LVL_PT   = 2'd3
    } level_t;

    localparam int ENT_PRESENT_BIT = 0;
    localparam int ENT_HUGE_BIT    = 7;

    function automatic logic [ADDR_W-1:0] entry_addr(
        input logic [ADDR_W-1:0] table_addr,
        input logic [VA_W-1:0]   vaddr,
        input level_t            level
    );
        logic [8:0]        idx;
        logic [ADDR_W-1:0] base;
        unique case (level)
            LVL_PML4: idx = vaddr[47:39];
            LVL_PDP:  idx = vaddr[38:30];
            LVL_PD:   idx = vaddr[29:21];
            LVL_PT:   idx = vaddr[20:12];
            default:  idx = vaddr[47:39];
        endcase
        base = table_addr & PA_MASK;
        return {base[ADDR_W-1:12], idx, 3'b000} & PA_MASK;
    endfunction

endpackage

### rtl/core/page_table_walk_translate.sv
// ============================================================================
// page_table_walk_translate
// Four-level x86-64 page table walker: issues one entry read per level and
// reports the translated address, page size or fault.
// Output: a result is held in the output register from the cycle after its item is accepted.
// Throughput: one transaction per cycle while m_ready holds; single output register.
// Reset: aresetn is synchronous, active low; clears the walk state, the root
// table register and the output valid.
// ============================================================================
module page_table_walk_translate
    import ptw_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,

    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [PADDR_W-1:0]  paddr,
    input  logic [DATA_W-1:0]   pwdata,
    output logic [DATA_W-1:0]   prdata,
    output logic                pready,

    input  logic                s_valid,
    output logic                s_ready,
    input  logic                s_func,
    input  logic [DATA_W-1:0]   s_virt_addr,
    input  logic [DATA_W-1:0]   s_read_data,

    output logic                m_valid,
    input  logic                m_ready,
    output logic                m_kind,
    output logic [ADDR_W-1:0]   m_read_addr,
    output logic [ADDR_W-1:0]   m_phys_addr,
    output logic                m_mapped,
    output logic [1:0]          m_page_kind
);

    logic [ADDR_W-1:0] root_reg;
    logic              busy_reg, busy_next;
    level_t            level_reg, level_next;
    logic [VA_W-1:0]   vaddr_reg, vaddr_next;

    logic              m_valid_reg;
    logic              m_kind_reg;
    logic [ADDR_W-1:0] m_read_addr_reg;
    logic [ADDR_W-1:0] m_phys_addr_reg;
    logic              m_mapped_reg;
    logic [1:0]        m_page_kind_reg;

    logic              res_valid;
    logic              res_kind;
    logic [ADDR_W-1:0] res_read_addr;
    logic [ADDR_W-1:0] res_phys_addr;
    logic              res_mapped;
    logic [1:0]        res_page_kind;

    logic              in_acc;
    logic              cfg_wr;
    logic [ADDR_W-1:0] ent;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite;
    assign prdata  = (paddr[PADDR_W-1:3] == REG_ROOT_TABLE_ADDR[PADDR_W-1:3])
                     ? DATA_W'(root_reg) : '0;

    assign s_ready = !m_valid_reg || m_ready;
    assign in_acc  = s_valid && s_ready;
    assign ent     = s_read_data[ADDR_W-1:0] & PA_MASK;

    always_comb begin
        res_valid     = 1'b0;
        res_kind      = KIND_READ_REQ;
        res_read_addr = '0;
        res_phys_addr = '0;
        res_mapped    = 1'b0;
        res_page_kind = PAGE_4K;
        busy_next     = busy_reg;
        level_next    = level_reg;
        vaddr_next    = vaddr_reg;

        if (s_func == FUNC_TRANSLATE) begin
            if (!busy_reg) begin
                vaddr_next    = s_virt_addr[VA_W-1:0];
                busy_next     = 1'b1;
                level_next    = LVL_PML4;
                res_valid     = 1'b1;
                res_read_addr = entry_addr(root_reg, s_virt_addr[VA_W-1:0], LVL_PML4);
            end
        end else if (busy_reg) begin
            res_valid = 1'b1;
            if (!s_read_data[ENT_PRESENT_BIT]) begin
                res_kind   = KIND_DONE;
                busy_next  = 1'b0;
                level_next = LVL_PML4;
            end else if (level_reg != LVL_PT && s_read_data[ENT_HUGE_BIT]) begin
                res_kind   = KIND_DONE;
                busy_next  = 1'b0;
                level_next = LVL_PML4;
                if (level_reg == LVL_PDP) begin
                    res_phys_addr = {ent[ADDR_W-1:30], vaddr_reg[29:0]} & PA_MASK;
                    res_mapped    = 1'b1;
                    res_page_kind = PAGE_1G;
                end else if (level_reg == LVL_PD) begin
                    res_phys_addr = {ent[ADDR_W-1:21], vaddr_reg[20:0]} & PA_MASK;
                    res_mapped    = 1'b1;
                    res_page_kind = PAGE_2M;
                end
            end else if (level_reg == LVL_PT) begin
                res_kind      = KIND_DONE;
                busy_next     = 1'b0;
                level_next    = LVL_PML4;
                res_phys_addr = {ent[ADDR_W-1:12], vaddr_reg[11:0]} & PA_MASK;
                res_mapped    = 1'b1;
                res_page_kind = PAGE_4K;
            end else begin
                level_next    = level_t'(level_reg + 2'd1);
                res_read_addr = entry_addr(ent, vaddr_reg, level_t'(level_reg + 2'd1));
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            root_reg    <= '0;
            busy_reg    <= 1'b0;
            level_reg   <= LVL_PML4;
            vaddr_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (cfg_wr && paddr[PADDR_W-1:3] == REG_ROOT_TABLE_ADDR[PADDR_W-1:3]) begin
                root_reg <= pwdata[ADDR_W-1:0];
            end
            if (in_acc) begin
                busy_reg    <= busy_next;
                level_reg   <= level_next;
                vaddr_reg   <= vaddr_next;
                m_valid_reg <= res_valid;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (in_acc && res_valid) begin
            m_kind_reg      <= res_kind;
            m_read_addr_reg <= res_read_addr;
            m_phys_addr_reg <= res_phys_addr;
            m_mapped_reg    <= res_mapped;
            m_page_kind_reg <= res_page_kind;
        end
    end

    assign m_valid     = m_valid_reg;
    assign m_kind      = m_kind_reg;
    assign m_read_addr = m_read_addr_reg;
    assign m_phys_addr = m_phys_addr_reg;
    assign m_mapped    = m_mapped_reg;
    assign m_page_kind = m_page_kind_reg;

    a_start_walk: assert property (@(posedge aclk) disable iff (!aresetn)
        in_acc && s_func == FUNC_TRANSLATE && !busy_reg
        |=> busy_reg && level_reg == LVL_PML4 && m_valid && m_kind == KIND_READ_REQ)
        else $error("translate request did not start a walk");

    a_idle_level: assert property (@(posedge aclk) disable iff (!aresetn)
        !busy_reg |-> level_reg == LVL_PML4)
        else $error("idle walker holds a nonzero level");

    a_pt_ends: assert property (@(posedge aclk) disable iff (!aresetn)
        in_acc && s_func == FUNC_READ_RESP && busy_reg && level_reg == LVL_PT
        |=> !busy_reg && m_valid && m_kind == KIND_DONE)
        else $error("walk did not end after the PT entry");

    a_fault_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_kind == KIND_DONE && !m_mapped
        |-> m_phys_addr == '0 && m_page_kind == PAGE_4K && m_read_addr == '0)
        else $error("fault result carries nonzero fields");

    a_req_fields: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_kind == KIND_READ_REQ
        |-> m_phys_addr == '0 && !m_mapped && m_read_addr[2:0] == 3'b000)
        else $error("read request has malformed fields");

endmodule
